// File: rtl/eur_pkg.sv
// Shared constants, tables and helpers for the Euler rotation matrix block.
// No dependencies.
package eur_pkg;

   localparam int ANGLE_BITS  = 16;
   localparam int FRAC_BITS   = 14;
   localparam int TRIG_STAGES = 16;

   localparam int NUM_STAGES  = (TRIG_STAGES < 32) ? TRIG_STAGES : 32;
   localparam int TRIG_LAT    = NUM_STAGES + 2;
   localparam int MAT_LAT     = 5;
   localparam int TOTAL_LAT   = TRIG_LAT + MAT_LAT;

   localparam int OUT_SHIFT   = 30 - FRAC_BITS;
   localparam logic signed [34:0] OUT_RND = 35'sd1 <<< OUT_SHIFT >>> 1;
   localparam logic signed [34:0] ONE_Q   = 35'sd1 <<< FRAC_BITS;

   localparam logic signed [31:0] X_INIT = 32'sh26DD3B6A;

   localparam logic [31:0] ATAN_TURNS [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [31:0] cos_v;
      logic signed [31:0] sin_v;
   } trig_type;

   function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + (64'sd1 <<< 29);
      rnd_q30 = t[61:30];
   endfunction

   function automatic logic [15:0] to_out(input logic signed [32:0] v);
      logic signed [34:0] t;
      logic signed [34:0] r;
      t = 35'(v) + OUT_RND;
      r = t >>> OUT_SHIFT;
      if (r > ONE_Q) begin
         r = ONE_Q;
      end
      if (r < -ONE_Q) begin
         r = -ONE_Q;
      end
      to_out = r[15:0];
   endfunction

endpackage

// File: rtl/eur_sincos.sv
// Pipelined rotation-mode CORDIC: cosine and sine of a negated binary angle, Q30.
// Depends on eur_pkg.
module eur_sincos (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [eur_pkg::ANGLE_BITS-1:0] angle,
   output logic                          out_valid,
   output eur_pkg::trig_type             trig
);

   localparam int N = eur_pkg::NUM_STAGES;
   localparam int AB = eur_pkg::ANGLE_BITS;

   logic                 vld_ff  [0:N];
   logic signed [31:0]   x_ff    [0:N];
   logic signed [31:0]   y_ff    [0:N];
   logic signed [32:0]   z_ff    [0:N];
   logic [1:0]           quad_ff [0:N];

   logic [AB-1:0]        neg_in;
   logic signed [32:0]   z_in;

   assign neg_in = AB'(0) - angle;
   assign z_in   = 33'({neg_in[AB-3:0], {(32-AB){1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      x_ff[0]    <= eur_pkg::X_INIT;
      y_ff[0]    <= '0;
      z_ff[0]    <= z_in;
      quad_ff[0] <= neg_in[AB-1:AB-2];
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [32:0] zn_in;
      logic signed [32:0] atan_v;

      assign atan_v = 33'(eur_pkg::ATAN_TURNS[i]);

      always_comb begin
         if (!z_ff[i][32]) begin
            x_in  = x_ff[i] - (y_ff[i] >>> i);
            y_in  = y_ff[i] + (x_ff[i] >>> i);
            zn_in = z_ff[i] - atan_v;
         end else begin
            x_in  = x_ff[i] + (y_ff[i] >>> i);
            y_in  = y_ff[i] - (x_ff[i] >>> i);
            zn_in = z_ff[i] + atan_v;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         x_ff[i+1]    <= x_in;
         y_ff[i+1]    <= y_in;
         z_ff[i+1]    <= zn_in;
         quad_ff[i+1] <= quad_ff[i];
      end
   end

   logic              out_vld_ff;
   eur_pkg::trig_type trig_ff;
   eur_pkg::trig_type trig_in;

   always_comb begin
      case (quad_ff[N])
         2'd0: begin
            trig_in.cos_v = x_ff[N];
            trig_in.sin_v = y_ff[N];
         end
         2'd1: begin
            trig_in.cos_v = -y_ff[N];
            trig_in.sin_v = x_ff[N];
         end
         2'd2: begin
            trig_in.cos_v = -x_ff[N];
            trig_in.sin_v = -y_ff[N];
         end
         default: begin
            trig_in.cos_v = y_ff[N];
            trig_in.sin_v = -x_ff[N];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[N];
      end
      trig_ff <= trig_in;
   end

   assign out_valid = out_vld_ff;
   assign trig      = trig_ff;

endmodule

// File: rtl/euler_rotation_matrix_top.sv
// Top level: Euler angles to the 3x3 rotation matrix Rz(-z)*Ry(-y)*Rx(-x), Q1.14.
// Depends on eur_pkg and eur_sincos.
//
// Usage:
//   Input: drive req_angle_x/y/z and raise start; the item is taken at any
//   rising edge where start is high and busy is low. busy is high only while
//   reset is held, so one item can be taken every cycle.
//   Output: rsp_valid pulses for one cycle with the nine entries rsp_r00 to
//   rsp_r22 (row-major, signed Q1.14, saturated to plus or minus one).
//   Pipeline: from accept to rsp_valid an item passes one angle stage, one
//   register per CORDIC stage (16 CORDIC stages), one quadrant stage,
//   then two multiply and two rounding stages and an output stage.
//   Throughput: one item per cycle outside reset, set by the fully pipelined
//   CORDIC units (one per axis) and the product stages.
//   Reset: synchronous; clears all valid bits, so items in flight are dropped.
//   The receiver cannot stall: each result is shown for exactly one cycle.
module euler_rotation_matrix_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_angle_x,
   input  logic [15:0] req_angle_y,
   input  logic [15:0] req_angle_z,
   output logic        rsp_valid,
   output logic signed [15:0] rsp_r00,
   output logic signed [15:0] rsp_r01,
   output logic signed [15:0] rsp_r02,
   output logic signed [15:0] rsp_r10,
   output logic signed [15:0] rsp_r11,
   output logic signed [15:0] rsp_r12,
   output logic signed [15:0] rsp_r20,
   output logic signed [15:0] rsp_r21,
   output logic signed [15:0] rsp_r22
);

   localparam int AB = eur_pkg::ANGLE_BITS;

   logic              acc;
   logic              tv_x, tv_y, tv_z;
   eur_pkg::trig_type tx, ty, tz;

   assign busy = reset;
   assign acc  = start & ~busy;

   eur_sincos u_sc_x (.clock(clock), .reset(reset), .in_valid(acc),
      .angle(req_angle_x[AB-1:0]), .out_valid(tv_x), .trig(tx));
   eur_sincos u_sc_y (.clock(clock), .reset(reset), .in_valid(acc),
      .angle(req_angle_y[AB-1:0]), .out_valid(tv_y), .trig(ty));
   eur_sincos u_sc_z (.clock(clock), .reset(reset), .in_valid(acc),
      .angle(req_angle_z[AB-1:0]), .out_valid(tv_z), .trig(tz));

   logic vld_ff [0:4];

   // stage M1
   logic signed [63:0] m_czsy_ff, m_szsy_ff, m_czcy_ff, m_szcy_ff, m_cysx_ff;
   logic signed [63:0] m_cycx_ff, m_szcx_ff, m_szsx_ff, m_czcx_ff, m_czsx_ff;
   logic signed [31:0] m_sx_ff, m_cx_ff;
   logic signed [32:0] m_nsy_ff;

   // stage R1
   logic signed [31:0] a_czsy_ff, a_szsy_ff, a_czcy_ff, a_szcy_ff, a_cysx_ff;
   logic signed [31:0] a_cycx_ff, a_szcx_ff, a_szsx_ff, a_czcx_ff, a_czsx_ff;
   logic signed [31:0] a_sx_ff, a_cx_ff;
   logic signed [32:0] a_nsy_ff;

   // stage M2
   logic signed [63:0] b_p1_ff, b_p2_ff, b_p3_ff, b_p4_ff;
   logic signed [31:0] b_czcy_ff, b_szcy_ff, b_cysx_ff, b_cycx_ff;
   logic signed [31:0] b_szcx_ff, b_szsx_ff, b_czcx_ff, b_czsx_ff;
   logic signed [32:0] b_nsy_ff;

   // stage R2
   logic signed [32:0] e_ff [0:8];

   // output stage
   logic [15:0] o_ff [0:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 5; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= tv_x & tv_y & tv_z;
         for (int k = 1; k < 5; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      m_czsy_ff <= tz.cos_v * ty.sin_v;
      m_szsy_ff <= tz.sin_v * ty.sin_v;
      m_czcy_ff <= tz.cos_v * ty.cos_v;
      m_szcy_ff <= tz.sin_v * ty.cos_v;
      m_cysx_ff <= ty.cos_v * tx.sin_v;
      m_cycx_ff <= ty.cos_v * tx.cos_v;
      m_szcx_ff <= tz.sin_v * tx.cos_v;
      m_szsx_ff <= tz.sin_v * tx.sin_v;
      m_czcx_ff <= tz.cos_v * tx.cos_v;
      m_czsx_ff <= tz.cos_v * tx.sin_v;
      m_sx_ff   <= tx.sin_v;
      m_cx_ff   <= tx.cos_v;
      m_nsy_ff  <= -33'(ty.sin_v);

      a_czsy_ff <= eur_pkg::rnd_q30(m_czsy_ff);
      a_szsy_ff <= eur_pkg::rnd_q30(m_szsy_ff);
      a_czcy_ff <= eur_pkg::rnd_q30(m_czcy_ff);
      a_szcy_ff <= eur_pkg::rnd_q30(m_szcy_ff);
      a_cysx_ff <= eur_pkg::rnd_q30(m_cysx_ff);
      a_cycx_ff <= eur_pkg::rnd_q30(m_cycx_ff);
      a_szcx_ff <= eur_pkg::rnd_q30(m_szcx_ff);
      a_szsx_ff <= eur_pkg::rnd_q30(m_szsx_ff);
      a_czcx_ff <= eur_pkg::rnd_q30(m_czcx_ff);
      a_czsx_ff <= eur_pkg::rnd_q30(m_czsx_ff);
      a_sx_ff   <= m_sx_ff;
      a_cx_ff   <= m_cx_ff;
      a_nsy_ff  <= m_nsy_ff;

      b_p1_ff   <= a_czsy_ff * a_sx_ff;
      b_p2_ff   <= a_czsy_ff * a_cx_ff;
      b_p3_ff   <= a_szsy_ff * a_sx_ff;
      b_p4_ff   <= a_szsy_ff * a_cx_ff;
      b_czcy_ff <= a_czcy_ff;
      b_szcy_ff <= a_szcy_ff;
      b_cysx_ff <= a_cysx_ff;
      b_cycx_ff <= a_cycx_ff;
      b_szcx_ff <= a_szcx_ff;
      b_szsx_ff <= a_szsx_ff;
      b_czcx_ff <= a_czcx_ff;
      b_czsx_ff <= a_czsx_ff;
      b_nsy_ff  <= a_nsy_ff;

      e_ff[0] <= 33'(b_czcy_ff);
      e_ff[1] <= 33'(eur_pkg::rnd_q30(b_p1_ff)) - 33'(b_szcx_ff);
      e_ff[2] <= 33'(eur_pkg::rnd_q30(b_p2_ff)) + 33'(b_szsx_ff);
      e_ff[3] <= 33'(b_szcy_ff);
      e_ff[4] <= 33'(eur_pkg::rnd_q30(b_p3_ff)) + 33'(b_czcx_ff);
      e_ff[5] <= 33'(eur_pkg::rnd_q30(b_p4_ff)) - 33'(b_czsx_ff);
      e_ff[6] <= b_nsy_ff;
      e_ff[7] <= 33'(b_cysx_ff);
      e_ff[8] <= 33'(b_cycx_ff);

      for (int k = 0; k < 9; k++) begin
         o_ff[k] <= eur_pkg::to_out(e_ff[k]);
      end
   end

   assign rsp_valid = vld_ff[4];
   assign rsp_r00   = o_ff[0];
   assign rsp_r01   = o_ff[1];
   assign rsp_r02   = o_ff[2];
   assign rsp_r10   = o_ff[3];
   assign rsp_r11   = o_ff[4];
   assign rsp_r12   = o_ff[5];
   assign rsp_r20   = o_ff[6];
   assign rsp_r21   = o_ff[7];
   assign rsp_r22   = o_ff[8];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      acc |-> ##(eur_pkg::TOTAL_LAT) rsp_valid)
      else $error("accepted item did not come out at the expected latency");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      (tv_x == tv_y) && (tv_y == tv_z))
      else $error("trig lanes out of step");

   a_r20_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_r20 <= 16'sd16384) && (rsp_r20 >= -16'sd16384)))
      else $error("r20 outside unit range");

endmodule
